/* rtl/core/gpg_pkg.sv */
// Shared types, constants and table functions for the Gabor pixel generator.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package gpg_pkg;

   // Register map, index = byte address / 4.
   typedef enum logic [2:0] {
      REG_WIDTH     = 3'd0,
      REG_HEIGHT    = 3'd1,
      REG_SIGMA     = 3'd2,
      REG_ORIENT    = 3'd3,
      REG_FREQ      = 3'd4,
      REG_PHASE     = 3'd5,
      REG_CONTRAST  = 3'd6,
      REG_UNUSED    = 3'd7
   } reg_index_type;

   localparam logic [10:0] WIDTH_RESET    = 11'd200;
   localparam logic [10:0] HEIGHT_RESET   = 11'd200;
   localparam logic [9:0]  SIGMA_RESET    = 10'd25;
   localparam logic [15:0] ORIENT_RESET   = 16'd5461;
   localparam logic [15:0] FREQ_RESET     = 16'd2185;
   localparam logic [15:0] PHASE_RESET    = 16'd2560;
   localparam logic [15:0] CONTRAST_RESET = 16'd32768;
   localparam logic [15:0] CONTRAST_MAX   = 16'd32768;

   // log2(e)/8 in Q16.
   localparam logic [13:0] LOG2E_Q16 = 14'd11819;

   // Quotient bits of the envelope exponent b (integer part up to 31).
   localparam int QBITS = 21;
   localparam int NUM_W = 37;
   localparam int SIG2_W = 20;

   // Centered half-pixel coordinates.
   typedef struct packed {
      logic signed [11:0] x2;
      logic signed [11:0] y2;
   } geom_type;

   // Carrier term: sign of the sine and |sin| * contrast.
   typedef struct packed {
      logic        neg;
      logic [31:0] sc;
   } mix_type;

   // Envelope exponent from the divider.
   typedef struct packed {
      logic             ovf;
      logic [QBITS-1:0] b;
   } quot_type;

   // Q15 quarter-wave sine table, 17 points.
   function automatic logic [15:0] sine_tab(input logic [4:0] i);
      logic [15:0] v;
      case (i)
         5'd0:  v = 16'd0;
         5'd1:  v = 16'd3212;
         5'd2:  v = 16'd6393;
         5'd3:  v = 16'd9512;
         5'd4:  v = 16'd12540;
         5'd5:  v = 16'd15447;
         5'd6:  v = 16'd18205;
         5'd7:  v = 16'd20788;
         5'd8:  v = 16'd23170;
         5'd9:  v = 16'd25330;
         5'd10: v = 16'd27246;
         5'd11: v = 16'd28899;
         5'd12: v = 16'd30274;
         5'd13: v = 16'd31357;
         5'd14: v = 16'd32138;
         5'd15: v = 16'd32610;
         default: v = 16'd32768;
      endcase
      return v;
   endfunction

   // Q16 table of 2^-f over one octave, 17 points.
   function automatic logic [16:0] exp_tab(input logic [4:0] i);
      logic [16:0] v;
      case (i)
         5'd0:  v = 17'd65536;
         5'd1:  v = 17'd62757;
         5'd2:  v = 17'd60097;
         5'd3:  v = 17'd57549;
         5'd4:  v = 17'd55109;
         5'd5:  v = 17'd52773;
         5'd6:  v = 17'd50535;
         5'd7:  v = 17'd48393;
         5'd8:  v = 17'd46341;
         5'd9:  v = 17'd44376;
         5'd10: v = 17'd42495;
         5'd11: v = 17'd40693;
         5'd12: v = 17'd38968;
         5'd13: v = 17'd37316;
         5'd14: v = 17'd35734;
         5'd15: v = 17'd34219;
         default: v = 17'd32768;
      endcase
      return v;
   endfunction

   // Q15 sine of a 16-bit turn angle, interpolated between table points.
   function automatic logic signed [16:0] sine_of(input logic [15:0] a);
      logic [14:0] p;
      logic [4:0]  idx;
      logic [15:0] lo;
      logic [15:0] hi;
      logic [21:0] t;
      logic [16:0] mag;
      p = {1'b0, a[13:0]};
      if (a[14]) begin
         p = 15'h4000 - p;
      end
      idx = p[14:10];
      lo  = sine_tab(idx);
      hi  = sine_tab(idx + 5'd1);
      t   = 22'(hi - lo) * 22'(p[9:0]) + 22'd512;
      if (idx[4]) begin
         mag = 17'd32768;
      end else begin
         mag = 17'(lo) + 17'(t[21:10]);
      end
      return a[15] ? -$signed(mag) : $signed(mag);
   endfunction

endpackage

`default_nettype wire

/* rtl/core/gpg_carrier.sv */
// Carrier pipeline: projection, angle, sine and contrast scaling in six stages.
// Depends on gpg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gpg_carrier
   import gpg_pkg::*;
(
   input  wire                clock,
   input  wire                reset,
   input  wire                adv,
   input  wire                in_vld,
   input  geom_type           in_geom,
   input  wire [6:0]          in_frame,
   input  wire signed [16:0]  so,
   input  wire signed [16:0]  co,
   input  wire [15:0]         freq,
   input  wire [15:0]         step,
   input  wire [15:0]         con,
   output logic               out_vld,
   output geom_type           out_geom,
   output mix_type            out_mix
);

   logic [5:0]         vld_ff;
   geom_type           g_ff [0:5];
   logic signed [28:0] px_ff, py_ff;
   logic [15:0]        ph1_ff, ph2_ff, ph3_ff;
   logic signed [29:0] proj_ff;
   logic [31:0]        fp_ff;
   logic [15:0]        ang_ff;
   logic               neg5_ff, neg6_ff;
   logic [15:0]        smag_ff;
   logic [31:0]        sc_ff;

   logic signed [46:0] fp_in;
   logic [31:0]        rnd_in;
   logic signed [16:0] sv_in;
   logic [22:0]        ph_in;

   always_comb begin
      fp_in  = $signed({31'b0, freq}) * 47'(proj_ff);
      rnd_in = fp_ff + 32'h8000;
      sv_in  = sine_of(ang_ff);
      ph_in  = 23'(in_frame) * 23'(step);
   end

   // Valid bits travel with the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[4:0], in_vld};
      end
   end

   // Stage payloads.
   always_ff @(posedge clock) begin
      if (adv) begin
         g_ff[0] <= in_geom;
         for (int i = 1; i < 6; i++) begin
            g_ff[i] <= g_ff[i-1];
         end
         px_ff   <= 29'(in_geom.x2 * so);
         py_ff   <= 29'(in_geom.y2 * co);
         ph1_ff  <= ph_in[15:0];
         proj_ff <= 30'(px_ff) + 30'(py_ff);
         ph2_ff  <= ph1_ff;
         fp_ff   <= fp_in[31:0];
         ph3_ff  <= ph2_ff;
         ang_ff  <= rnd_in[31:16] + ph3_ff;
         neg5_ff <= sv_in[16];
         smag_ff <= sv_in[16] ? 16'(-sv_in) : sv_in[15:0];
         neg6_ff <= neg5_ff;
         sc_ff   <= smag_ff * con;
      end
   end

   assign out_vld    = vld_ff[5];
   assign out_geom   = g_ff[5];
   assign out_mix.neg = neg6_ff;
   assign out_mix.sc  = sc_ff;

endmodule

`default_nettype wire

/* rtl/core/gpg_divider.sv */
// Envelope exponent: radius squared times log2(e)/8, divided by sigma squared
// with one quotient bit per stage. Depends on gpg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gpg_divider
   import gpg_pkg::*;
(
   input  wire               clock,
   input  wire               reset,
   input  wire               adv,
   input  wire               in_vld,
   input  geom_type          in_geom,
   input  mix_type           in_mix,
   input  wire [SIG2_W-1:0]  sig2,
   output logic              out_vld,
   output mix_type           out_mix,
   output quot_type          out_quot
);

   localparam int TRIAL_W = NUM_W + QBITS;

   logic [22:0]      r2_ff;
   logic [NUM_W-1:0] num_ff;
   logic [2:0]       pre_vld_ff;
   mix_type          pre_mix_ff [0:1];

   logic [QBITS-1:0] vld_ff;
   logic [NUM_W-1:0] rem_ff [0:QBITS];
   logic [QBITS-1:0] q_ff   [0:QBITS];
   logic             ovf_ff [0:QBITS];
   mix_type          mix_ff [0:QBITS];

   // Front stages: squared radius, scaling and overflow check.
   always_ff @(posedge clock) begin
      if (reset) begin
         pre_vld_ff <= '0;
      end else if (adv) begin
         pre_vld_ff <= {pre_vld_ff[1:0], in_vld};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         r2_ff  <= 23'(in_geom.x2 * in_geom.x2) + 23'(in_geom.y2 * in_geom.y2);
         num_ff <= NUM_W'(r2_ff) * NUM_W'(LOG2E_Q16);
         pre_mix_ff[0] <= in_mix;
         pre_mix_ff[1] <= pre_mix_ff[0];
         rem_ff[0] <= num_ff;
         q_ff[0]   <= '0;
         ovf_ff[0] <= (NUM_W'(num_ff >> QBITS) >= NUM_W'(sig2));
         mix_ff[0] <= pre_mix_ff[1];
      end
   end

   // Valid bit i travels with quotient stage i+1.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[QBITS-2:0], pre_vld_ff[2]};
      end
   end

   // One restoring step per stage, most significant quotient bit first.
   for (genvar i = 0; i < QBITS; i++) begin : g_step
      localparam int K = QBITS - 1 - i;
      logic [TRIAL_W:0] trial;
      assign trial = {1'b0, TRIAL_W'(rem_ff[i])} - ((TRIAL_W + 1)'(sig2) << K);
      always_ff @(posedge clock) begin
         if (adv) begin
            ovf_ff[i+1] <= ovf_ff[i];
            mix_ff[i+1] <= mix_ff[i];
            if (!trial[TRIAL_W]) begin
               rem_ff[i+1] <= trial[NUM_W-1:0];
               q_ff[i+1]   <= q_ff[i] | (QBITS'(1) << K);
            end else begin
               rem_ff[i+1] <= rem_ff[i];
               q_ff[i+1]   <= q_ff[i];
            end
         end
      end
   end

   assign out_vld      = vld_ff[QBITS-1];
   assign out_mix      = mix_ff[QBITS];
   assign out_quot.ovf = ovf_ff[QBITS];
   assign out_quot.b   = q_ff[QBITS];

endmodule

`default_nettype wire

/* rtl/core/gpg_mixer.sv */
// Envelope lookup, carrier-envelope product and grey conversion in four
// stages; the last stage is the output register. Depends on gpg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gpg_mixer
   import gpg_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   input  wire         adv,
   input  wire         in_vld,
   input  mix_type     in_mix,
   input  quot_type    in_quot,
   output logic        out_vld,
   output logic [7:0]  out_grey
);

   logic [3:0]  vld_ff;
   mix_type     mix_ff;
   logic [16:0] env_ff;
   logic        neg2_ff;
   logic [46:0] m_ff;
   logic [47:0] n_ff;
   logic [7:0]  grey_ff;

   logic [4:0]  ip;
   logic [16:0] lo, hi, e_in;
   logic [23:0] t;
   logic [16:0] env_in;
   logic [48:0] m_in;
   logic [55:0] g_in;

   // 2^-b from the table, interpolated, then shifted by the integer part.
   always_comb begin
      ip = in_quot.b[20:16];
      lo = exp_tab({1'b0, in_quot.b[15:12]});
      hi = exp_tab({1'b0, in_quot.b[15:12]} + 5'd1);
      t  = 24'(lo - hi) * 24'(in_quot.b[11:0]) + 24'd2048;
      e_in = lo - 17'(t[23:12]);
      if (in_quot.ovf || ip >= 5'd17) begin
         env_in = '0;
      end else begin
         env_in = e_in >> ip;
      end
      m_in = 49'(mix_ff.sc) * 49'(env_ff);
      g_in = {n_ff, 8'b0} - 56'(n_ff) + (56'd1 << 46);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[2:0], in_vld};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mix_ff  <= in_mix;
         env_ff  <= env_in;
         neg2_ff <= mix_ff.neg;
         m_ff    <= m_in[46:0];
         n_ff    <= neg2_ff ? (48'd1 << 46) - 48'(m_ff) : (48'd1 << 46) + 48'(m_ff);
         grey_ff <= g_in[55] ? 8'hFF : g_in[54:47];
      end
   end

   assign out_vld  = vld_ff[3];
   assign out_grey = grey_ff;

endmodule

`default_nettype wire

/* rtl/core/drifting_gabor_pixel_generator.sv */
// Drifting Gabor patch pixel generator, top level: register file, input
// stage and the carrier, divider and mixer pipelines. Depends on gpg_pkg.
//
// Usage: each item on the req_ stream names one pixel (column, row, frame);
// the rsp_ stream returns one 8-bit grey value per item, in order.
// The block takes one item per clock while the pipeline advances. An item
// passes 35 register stages: one input stage, six carrier stages, three
// front stages and 21 quotient stages of the envelope divider, and four
// mixing stages.
// The pipeline moves as a whole: when the receiver holds rsp_tready low
// with a result waiting, every stage holds and req_tready drops; a slot
// that is empty at the output lets the pipeline advance.
// Configuration registers sit on the csr_ APB port at byte address 4*index;
// write them only while no item is in flight.
// Reset empties the pipeline and restores every register to its default.
`timescale 1ns / 1ps
`default_nettype none

module drifting_gabor_pixel_generator
   import gpg_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire [31:0]  req_tdata,    // column[9:0], row[19:10], frame_index[26:20]
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [7:0]  rsp_tdata,    // grey_level[7:0]
   input  wire         csr_psel,
   input  wire         csr_penable,
   input  wire         csr_pwrite,
   input  wire [4:0]   csr_paddr,
   input  wire [31:0]  csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [10:0] width_ff, height_ff;
   logic [9:0]  sigma_ff;
   logic [15:0] orient_ff, freq_ff, phase_ff, contrast_ff;

   logic signed [16:0] so_ff, co_ff;
   logic [SIG2_W-1:0]  s2_ff;
   logic [15:0]        con_ff;

   logic          adv;
   logic          in_vld_ff;
   geom_type      in_geom_ff;
   logic [6:0]    in_frame_ff;

   logic          car_vld;
   geom_type      car_geom;
   mix_type       car_mix;
   logic          div_vld;
   mix_type       div_mix;
   quot_type      div_quot;

   reg_index_type csr_idx;
   logic          csr_wr;
   logic [9:0]    sig_in;

   assign csr_idx    = reg_index_type'(csr_paddr[4:2]);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   // Register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= WIDTH_RESET;
         height_ff   <= HEIGHT_RESET;
         sigma_ff    <= SIGMA_RESET;
         orient_ff   <= ORIENT_RESET;
         freq_ff     <= FREQ_RESET;
         phase_ff    <= PHASE_RESET;
         contrast_ff <= CONTRAST_RESET;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_WIDTH:    width_ff    <= csr_pwdata[10:0];
            REG_HEIGHT:   height_ff   <= csr_pwdata[10:0];
            REG_SIGMA:    sigma_ff    <= csr_pwdata[9:0];
            REG_ORIENT:   orient_ff   <= csr_pwdata[15:0];
            REG_FREQ:     freq_ff     <= csr_pwdata[15:0];
            REG_PHASE:    phase_ff    <= csr_pwdata[15:0];
            REG_CONTRAST: contrast_ff <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   // Register reads.
   always_comb begin
      case (csr_idx)
         REG_WIDTH:    csr_prdata = 32'(width_ff);
         REG_HEIGHT:   csr_prdata = 32'(height_ff);
         REG_SIGMA:    csr_prdata = 32'(sigma_ff);
         REG_ORIENT:   csr_prdata = 32'(orient_ff);
         REG_FREQ:     csr_prdata = 32'(freq_ff);
         REG_PHASE:    csr_prdata = 32'(phase_ff);
         REG_CONTRAST: csr_prdata = 32'(contrast_ff);
         default:      csr_prdata = '0;
      endcase
   end

   // Values derived from the registers, refreshed every cycle.
   assign sig_in = (sigma_ff == '0) ? 10'd1 : sigma_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ff  <= SIG2_W'(SIGMA_RESET) * SIG2_W'(SIGMA_RESET);
         con_ff <= CONTRAST_RESET;
      end else begin
         s2_ff  <= SIG2_W'(sig_in) * SIG2_W'(sig_in);
         con_ff <= (contrast_ff > CONTRAST_MAX) ? CONTRAST_MAX : contrast_ff;
      end
      so_ff <= sine_of(orient_ff);
      co_ff <= sine_of(orient_ff + 16'h4000);
   end

   // The whole pipeline advances unless a result is held at the output.
   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   // Input stage: centered half-pixel coordinates.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (adv) begin
         in_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         in_geom_ff.x2 <= $signed({1'b0, req_tdata[9:0], 1'b0}) - $signed({1'b0, width_ff});
         in_geom_ff.y2 <= $signed({1'b0, req_tdata[19:10], 1'b0}) - $signed({1'b0, height_ff});
         in_frame_ff   <= req_tdata[26:20];
      end
   end

   gpg_carrier u_carrier (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_vld   (in_vld_ff),
      .in_geom  (in_geom_ff),
      .in_frame (in_frame_ff),
      .so       (so_ff),
      .co       (co_ff),
      .freq     (freq_ff),
      .step     (phase_ff),
      .con      (con_ff),
      .out_vld  (car_vld),
      .out_geom (car_geom),
      .out_mix  (car_mix)
   );

   gpg_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_vld   (car_vld),
      .in_geom  (car_geom),
      .in_mix   (car_mix),
      .sig2     (s2_ff),
      .out_vld  (div_vld),
      .out_mix  (div_mix),
      .out_quot (div_quot)
   );

   gpg_mixer u_mixer (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_vld   (div_vld),
      .in_mix   (div_mix),
      .in_quot  (div_quot),
      .out_vld  (rsp_tvalid),
      .out_grey (rsp_tdata)
   );

   // The divisor never reaches zero.
   a_sig2_nonzero: assert property (@(posedge clock) disable iff (reset)
      s2_ff != '0)
      else $error("sigma squared is zero");

   // Contrast stays clamped to one.
   a_con_clamped: assert property (@(posedge clock) disable iff (reset)
      con_ff <= CONTRAST_MAX)
      else $error("contrast above one");

   // A stall freezes the divider output stage.
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(div_quot) && $stable(div_vld))
      else $error("divider moved during stall");

endmodule

`default_nettype wire

/* verif/drifting_gabor_pixel_generator_tb.sv */
// Self-checking testbench for the drifting Gabor pixel generator.
// A scoreboard class predicts each grey level from the pixel and the register values.
// Depends on gpg_pkg and drifting_gabor_pixel_generator.
`timescale 1ns / 1ps

// Predicts grey levels for accepted pixels and compares them in order.
class grey_scoreboard;
   logic [10:0] img_w, img_h;
   logic [9:0]  sig;
   logic [15:0] orient, freq, pstep, contrast;
   logic [7:0]  pending_grey[$];
   int          errors;
   int          checked;

   function new();
      img_w = 200; img_h = 200; sig = 25; orient = 5461; freq = 2185;
      pstep = 2560; contrast = 32768;
      errors = 0; checked = 0;
   endfunction

   // Mirror of one register write.
   function void set_reg(gpg_pkg::reg_index_type idx, logic [31:0] v);
      case (idx)
         gpg_pkg::REG_WIDTH:    img_w = v[10:0];
         gpg_pkg::REG_HEIGHT:   img_h = v[10:0];
         gpg_pkg::REG_SIGMA:    sig = v[9:0];
         gpg_pkg::REG_ORIENT:   orient = v[15:0];
         gpg_pkg::REG_FREQ:     freq = v[15:0];
         gpg_pkg::REG_PHASE:    pstep = v[15:0];
         gpg_pkg::REG_CONTRAST: contrast = v[15:0];
         default: ;
      endcase
   endfunction

   // Interpolated Q15 sine of a 16-bit turn angle.
   function longint sine_q15(logic [15:0] a);
      longint tab[17] = '{0, 3212, 6393, 9512, 12540, 15447, 18205, 20788, 23170,
                          25330, 27246, 28899, 30274, 31357, 32138, 32610, 32768};
      longint p, idx, fr, mag;
      p = a[13:0];
      if (a[14]) p = 16384 - p;
      idx = p >> 10;
      fr = p & 1023;
      if (idx >= 16) mag = tab[16];
      else mag = tab[idx] + (((tab[idx+1] - tab[idx]) * fr + 512) >>> 10);
      return a[15] ? -mag : mag;
   endfunction

   // Q16 Gaussian envelope from the squared half-pixel radius.
   function longint envelope_q16(longint r2, longint s);
      longint tab[17] = '{65536, 62757, 60097, 57549, 55109, 52773, 50535, 48393,
                          46341, 44376, 42495, 40693, 38968, 37316, 35734, 34219,
                          32768};
      longint b, ip, idx, f, e;
      b = (r2 * 11819) / (s * s);
      ip = b >>> 16;
      if (ip >= 17) return 0;
      idx = (b >>> 12) & 15;
      f = b & 4095;
      e = tab[idx] - (((tab[idx] - tab[idx+1]) * f + 2048) >>> 12);
      return e >>> ip;
   endfunction

   // Notes an accepted pixel and queues its expected grey level.
   function void note_pixel(logic [9:0] col, logic [9:0] row, logic [6:0] frame);
      longint x2, y2, s, con, so, co, proj, sv, env, smag;
      logic [63:0] prod, m, n, g;
      logic [15:0] ang;
      x2 = 2 * longint'(col) - longint'(img_w);
      y2 = 2 * longint'(row) - longint'(img_h);
      s = (sig == 0) ? 1 : sig;
      con = (contrast > 32768) ? 32768 : contrast;
      so = sine_q15(orient);
      co = sine_q15(orient + 16'h4000);
      proj = x2 * so + y2 * co;
      prod = 64'(freq) * 64'(proj);
      ang = 16'((prod + 64'h8000) >> 16);
      ang = ang + 16'(frame * pstep);
      sv = sine_q15(ang);
      env = envelope_q16(x2 * x2 + y2 * y2, s);
      smag = sv < 0 ? -sv : sv;
      m = 64'(smag) * 64'(con) * 64'(env);
      n = (sv < 0) ? (64'd1 << 46) - m : (64'd1 << 46) + m;
      g = (64'd255 * n + (64'd1 << 46)) >> 47;
      pending_grey.push_back(g > 255 ? 8'd255 : g[7:0]);
   endfunction

   // Checks one grey level against the oldest prediction.
   function void check_grey(logic [7:0] got);
      logic [7:0] want;
      if (pending_grey.size() == 0) begin
         $display("%0t: unexpected grey level, expected none, actual %0d", $time, got);
         errors++;
         return;
      end
      want = pending_grey.pop_front();
      checked++;
      if (got !== want) begin
         $display("%0t: grey_level mismatch, expected %0d, actual %0d", $time, want, got);
         errors++;
      end
   endfunction
endclass

module drifting_gabor_pixel_generator_tb
   import gpg_pkg::*;
;

   localparam int LATENCY = 35;
   localparam longint CYCLE_LIMIT = 400000;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   wire         req_tready;
   logic [31:0] req_tdata = 0;
   wire         rsp_tvalid;
   logic        rsp_tready = 0;
   wire  [7:0]  rsp_tdata;
   logic        csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [4:0]  csr_paddr = 0;
   logic [31:0] csr_pwdata = 0;
   wire  [31:0] csr_prdata;
   wire         csr_pready;

   grey_scoreboard board = new();
   longint cycles = 0;
   int     idle_pct = 24;     // shared by both sides; zero during the quiet stretch
   bit     hold_off = 0;
   int     pixels_sent = 0;
   int     cfg_writes = 0;

   drifting_gabor_pixel_generator dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #1 clock = ~clock;

   // Run limit.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles.", cycles);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Receiver: random stalls, plus a long hold-off when asked.
   int hold_count = 0;
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_grey(rsp_tdata);
      if (hold_off && hold_count < 300) begin
         hold_count <= hold_count + 1;
         rsp_tready <= 0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= idle_pct);
      end
   end

   // APB write: setup phase, then access phase.
   task automatic write_reg(reg_index_type idx, logic [31:0] v);
      @(posedge clock);
      csr_psel <= 1; csr_penable <= 0; csr_pwrite <= 1;
      csr_paddr <= 5'(idx) << 2; csr_pwdata <= v;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
      board.set_reg(idx, v);
      cfg_writes++;
   endtask

   // Offers one pixel until it is accepted, with random gaps first. The valid
   // stays high afterwards so that the next item can follow without a gap.
   task automatic send_pixel(logic [9:0] col, logic [9:0] row, logic [6:0] frame);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {5'd0, frame, row, col};
      do @(posedge clock); while (!req_tready);
      board.note_pixel(col, row, frame);
      pixels_sent++;
   endtask

   // Waits until every prediction has been checked, then lets the pipe drain.
   task automatic drain();
      req_tvalid <= 0;
      while (board.pending_grey.size() != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   task automatic write_all(logic [31:0] w, logic [31:0] h, logic [31:0] s,
                            logic [31:0] o, logic [31:0] f, logic [31:0] p,
                            logic [31:0] c);
      write_reg(REG_WIDTH, w);  write_reg(REG_HEIGHT, h); write_reg(REG_SIGMA, s);
      write_reg(REG_ORIENT, o); write_reg(REG_FREQ, f);   write_reg(REG_PHASE, p);
      write_reg(REG_CONTRAST, c);
   endtask

   // Random pixels: mostly inside the image, some anywhere in the field range.
   task automatic random_pixels(int count);
      logic [9:0] col, row;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(3) == 0) begin
            col = 10'($urandom); row = 10'($urandom);
         end else begin
            col = 10'($urandom_range(board.img_w == 0 ? 0 : board.img_w - 1));
            row = 10'($urandom_range(board.img_h == 0 ? 0 : board.img_h - 1));
         end
         send_pixel(col, row, 7'($urandom));
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 0;

      // Directed part on reset values: centre, corners, field extremes, frames.
      send_pixel(100, 100, 0);
      send_pixel(0, 0, 0);
      send_pixel(1023, 1023, 127);
      send_pixel(199, 0, 64);
      send_pixel(0, 199, 1);
      send_pixel(110, 95, 127);
      send_pixel(90, 100, 5);
      send_pixel(10'h2AA, 10'h155, 7'h55);
      send_pixel(10'h155, 10'h2AA, 7'h2A);
      drain();

      // Zero sigma, zero size, contrast above one, unknown register index.
      write_all(0, 0, 0, 0, 65535, 65535, 65535);
      write_reg(REG_UNUSED, 32'hFFFF_FFFF);
      send_pixel(0, 0, 3);
      send_pixel(1, 0, 127);
      send_pixel(0, 1, 64);
      send_pixel(1023, 0, 1);
      drain();
      write_all(1024, 1024, 512, 65535, 0, 0, 0);
      send_pixel(512, 512, 0);
      send_pixel(0, 1023, 127);
      send_pixel(300, 700, 9);
      drain();
      write_all(1, 1, 1, 16384, 32768, 1, 32768);
      send_pixel(0, 0, 127);
      send_pixel(1023, 1023, 0);
      drain();

      // Eight phases of random pixels, each under one setting of the registers.
      for (int ph = 0; ph < 8; ph++) begin
         if (ph == 0) write_all(200, 200, 25, 5461, 2185, 2560, 32768);
         else if (ph == 1) write_all(16, 12, 3, $urandom, $urandom, $urandom, $urandom);
         else if (ph == 2) write_all(1024, 1024, 512, $urandom, 600, $urandom, 32768);
         else write_all($urandom_range(1, 1024), $urandom_range(1, 1024),
                        $urandom_range(1, 512), $urandom, $urandom_range(0, 8000),
                        $urandom, $urandom_range(0, 32768));
         if (ph == 3) begin
            // Receiver holds off while the sender keeps offering.
            hold_off = 1;
            random_pixels(60);
            hold_off = 0;
         end
         if (ph == 5) idle_pct = 0;   // long stretch with no idling
         random_pixels(235);
         idle_pct = 24;
         drain();
      end

      $display("Covered %0d pixels and %0d register writes over several settings.",
               pixels_sent, cfg_writes);
      $display("%0d grey levels checked, %0d mismatches.", board.checked, board.errors);
      if (board.errors == 0 && board.pending_grey.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end
endmodule
